/* hw/rtl/hsd_pkg.sv */
// Package for the two-stage handshake detector.
// Holds the transfer payload types, the match strings and their lookups.
// It has no dependencies. Both modules import it.
package hsd_pkg;

  // Length of the handshake string and of the command word.
  localparam int HS_LEN   = 14;
  localparam int WORD_LEN = 6;

  // Acknowledge byte that a caller sends when send_ack is set.
  localparam logic [7:0] ACK_CODE = 8'h06;

  // Widths of the match counters.
  localparam int HS_CNT_W   = 4;
  localparam int WORD_CNT_W = 3;

  // Matcher stage, one-hot.
  typedef enum logic [1:0] {
    ST_HANDSHAKE = 2'b01,
    ST_WORD      = 2'b10
  } hsd_stage_t;

  // Payload of one input transfer.
  typedef struct packed {
    logic [7:0] rx_byte;
  } hsd_item_t;

  // Payload of one result transfer.
  typedef struct packed {
    logic        send_ack;
    logic        enter_update;
    logic        stage_now;
    logic [3:0]  handshake_progress;
    logic [31:0] bytes_seen;
    logic        triggered_flag;
  } hsd_result_t;

  // Handshake string "PROGRAMBT9000U". Unused entries read as zero.
  function automatic logic [7:0] hs_char(input logic [HS_CNT_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "P";
      4'd1:    ch = "R";
      4'd2:    ch = "O";
      4'd3:    ch = "G";
      4'd4:    ch = "R";
      4'd5:    ch = "A";
      4'd6:    ch = "M";
      4'd7:    ch = "B";
      4'd8:    ch = "T";
      4'd9:    ch = "9";
      4'd10:   ch = "0";
      4'd11:   ch = "0";
      4'd12:   ch = "0";
      4'd13:   ch = "U";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Command word "UPDATE". Unused entries read as zero.
  function automatic logic [7:0] word_char(input logic [WORD_CNT_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "U";
      3'd1:    ch = "P";
      3'd2:    ch = "D";
      3'd3:    ch = "A";
      3'd4:    ch = "T";
      3'd5:    ch = "E";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* hw/rtl/hsd_stream_if.sv */
// Valid/ready stream interface used by both channels of the detector.
// The payload type is a parameter; the detector uses the structs of hsd_pkg.
interface hsd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  // The producer drives valid and data; the consumer drives ready.
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/hsd_matcher.sv */
// Sequence matcher state and next-state logic of the handshake detector.
// Depends on hsd_pkg for the match strings, stage type and result type.
// State advances only when the caller commits a byte.
module hsd_matcher
  import hsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        commit,
  input  logic [7:0]  rx_byte,
  output hsd_result_t result
);

  hsd_stage_t              stage_r, stage_nxt;
  logic [HS_CNT_W-1:0]     hs_cnt_r, hs_cnt_nxt;
  logic [WORD_CNT_W-1:0]   word_cnt_r, word_cnt_nxt;
  logic                    done_r, done_nxt;
  logic [31:0]             byte_cnt_r, byte_cnt_nxt;
  logic                    ack;
  logic                    enter;
  logic [HS_CNT_W:0]       hs_inc;
  logic [WORD_CNT_W:0]     word_inc;

  assign hs_inc   = {1'b0, hs_cnt_r} + 1'b1;
  assign word_inc = {1'b0, word_cnt_r} + 1'b1;

  // Next state for the byte being committed.
  always_comb begin
    stage_nxt    = stage_r;
    hs_cnt_nxt   = hs_cnt_r;
    word_cnt_nxt = word_cnt_r;
    done_nxt     = done_r;
    byte_cnt_nxt = byte_cnt_r + 32'd1;
    ack          = 1'b0;
    enter        = 1'b0;
    if (!done_r) begin
      case (stage_r)
        ST_HANDSHAKE: begin
          if (rx_byte == hs_char(hs_cnt_r)) begin
            if (hs_inc == (HS_CNT_W+1)'(HS_LEN)) begin
              hs_cnt_nxt = '0;
              stage_nxt  = ST_WORD;
              ack        = 1'b1;
            end else begin
              hs_cnt_nxt = hs_inc[HS_CNT_W-1:0];
            end
          end else begin
            hs_cnt_nxt = (rx_byte == hs_char('0)) ? HS_CNT_W'(1) : '0;
          end
        end
        ST_WORD: begin
          if (rx_byte == word_char(word_cnt_r)) begin
            if (word_inc == (WORD_CNT_W+1)'(WORD_LEN)) begin
              word_cnt_nxt = '0;
              done_nxt     = 1'b1;
              ack          = 1'b1;
              enter        = 1'b1;
            end else begin
              word_cnt_nxt = word_inc[WORD_CNT_W-1:0];
            end
          end else begin
            word_cnt_nxt = (rx_byte == word_char('0)) ? WORD_CNT_W'(1) : '0;
            // The first handshake character restarts the handshake.
            if (rx_byte == hs_char('0)) begin
              stage_nxt  = ST_HANDSHAKE;
              hs_cnt_nxt = HS_CNT_W'(1);
            end
          end
        end
        default: begin
          stage_nxt = ST_HANDSHAKE;
        end
      endcase
    end
  end

  // State registers, updated once per committed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r    <= ST_HANDSHAKE;
      hs_cnt_r   <= '0;
      word_cnt_r <= '0;
      done_r     <= 1'b0;
      byte_cnt_r <= '0;
    end else if (commit) begin
      stage_r    <= stage_nxt;
      hs_cnt_r   <= hs_cnt_nxt;
      word_cnt_r <= word_cnt_nxt;
      done_r     <= done_nxt;
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

  // Result fields reflect the state after this byte.
  always_comb begin
    result.send_ack           = ack;
    result.enter_update       = enter;
    result.stage_now          = (stage_nxt == ST_WORD);
    result.handshake_progress = hs_cnt_nxt;
    result.bytes_seen         = byte_cnt_nxt;
    result.triggered_flag     = done_nxt;
  end

`ifndef ASSERT_OFF
  // The trigger never clears once set.
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("trigger flag cleared");

  // Entering update mode always comes with an acknowledge.
  a_enter_acks: assert property (@(posedge clk) disable iff (!rst_n)
    enter |-> ack)
    else $error("enter_update without send_ack");

  // While waiting for the word, the handshake count is idle at zero.
  a_word_hs_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == ST_WORD) |-> (hs_cnt_r == '0))
    else $error("handshake count nonzero in word stage");

  // Counters never reach their full lengths.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(hs_cnt_r) < HS_LEN) && (32'(word_cnt_r) < WORD_LEN))
    else $error("match counter out of range");

  // Each committed byte advances the byte count by one.
  a_byte_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> (byte_cnt_r == $past(byte_cnt_r) + 32'd1))
    else $error("byte count did not advance");
`endif

endmodule

/* hw/rtl/two_stage_handshake_detector_core.sv */
// Top level of the two-stage handshake detector.
// Depends on hsd_pkg, hsd_stream_if and hsd_matcher.
//
//   Channel  Dir  Payload                                  Transfer when
//   in_ch    in   rx_byte[7:0]                             valid && ready
//   out_ch   out  send_ack, enter_update, stage_now,       valid && ready
//                 handshake_progress[3:0], bytes_seen[31:0],
//                 triggered_flag
//
// One byte per cycle sustained while out_ch does not stall; a result passes
// through the input register and then the result register before it is
// valid on out_ch.
// The matcher state advances as a byte moves from the input register into
// the result register, so results come out in input order.
// Reset (rst_n low, synchronous) empties both registers and clears all state.
// A stall on out_ch fills the result register, then the input register,
// and only then drops in_ch.ready.
module two_stage_handshake_detector_core
  import hsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  hsd_stream_if.sink   in_ch,
  hsd_stream_if.source out_ch
);

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        out_vld_r;
  hsd_result_t out_data_r;
  hsd_result_t result;
  logic        out_free;
  logic        commit;
  logic        in_free;

  // Pipeline flow control.
  assign out_free    = !out_vld_r || out_ch.ready;
  assign commit      = in_vld_r && out_free;
  assign in_free     = !in_vld_r || commit;
  assign in_ch.ready = in_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_free) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_ch.valid) begin
      in_byte_r <= in_ch.data.rx_byte;
    end
  end

  hsd_matcher u_matcher (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (commit),
    .rx_byte (in_byte_r),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

endmodule
